@@ hw/rtl/tcgr_pkg.sv @@
// Shared types and constants for the text console glyph renderer.
// No dependencies; every other file in hw/rtl uses this package.
package tcgr_pkg;

    // Default geometry, handed to the top-level parameters.
    localparam int GLYPH_HEIGHT_DEF = 20;
    localparam int GLYPH_WIDTH_DEF  = 10;
    localparam int ROW_BYTES_DEF    = 2;
    localparam int SCREEN_WIDTH_DEF = 1024;

    // Fixed field widths.
    localparam int CMD_W      = 2;
    localparam int CODE_W     = 8;
    localparam int COLOR_W    = 32;
    localparam int COORD_W    = 12;
    localparam int ADDR_W     = 14;
    localparam int BYTE_W     = 8;
    localparam int ROWBITS_W  = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT    = 2'd0,
        CMD_CURSOR = 2'd1,
        CMD_FONT   = 2'd2
    } t_cmd;

    // Control characters and substitute glyphs.
    localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CODE_W-1:0] CH_FORMFEED  = 8'h0C;
    localparam logic [CODE_W-1:0] GLYPH_BLOCK  = 8'hDB;
    localparam logic [CODE_W-1:0] GLYPH_BLANK  = 8'h00;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CONSOLE_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MARGIN = 1'd1;

    // One font byte write request.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_font_wr;

endpackage

@@ hw/rtl/tcgr_in_if.sv @@
// Command channel of the glyph renderer: valid/ready plus one command item.
// Depends on tcgr_pkg for field widths.
interface tcgr_in_if;
    logic                             valid;
    logic                             ready;
    logic [tcgr_pkg::CMD_W-1:0]       cmd;
    logic [tcgr_pkg::CODE_W-1:0]      char_code;
    logic [tcgr_pkg::COLOR_W-1:0]     draw_color;
    logic [tcgr_pkg::COORD_W-1:0]     new_x;
    logic [tcgr_pkg::COORD_W-1:0]     new_y;
    logic [tcgr_pkg::ADDR_W-1:0]      font_addr;
    logic [tcgr_pkg::BYTE_W-1:0]      font_byte;

    modport source (output valid, cmd, char_code, draw_color, new_x, new_y,
                    font_addr, font_byte, input ready);
    modport sink   (input valid, cmd, char_code, draw_color, new_x, new_y,
                    font_addr, font_byte, output ready);
endinterface

@@ hw/rtl/tcgr_out_if.sv @@
// Glyph row channel of the glyph renderer: valid/ready plus one row item.
// Depends on tcgr_pkg for field widths.
interface tcgr_out_if;
    logic                             valid;
    logic                             ready;
    logic [tcgr_pkg::COORD_W-1:0]     pixel_x;
    logic [tcgr_pkg::COORD_W-1:0]     pixel_y;
    logic [tcgr_pkg::ROWBITS_W-1:0]   row_bits;
    logic [tcgr_pkg::COLOR_W-1:0]     pixel_color;
    logic                             last_row;

    modport source (output valid, pixel_x, pixel_y, row_bits, pixel_color, last_row,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, row_bits, pixel_color, last_row,
                    output ready);
endinterface

@@ hw/rtl/tcgr_font_store.sv @@
// Font store: one synchronous RAM word per glyph row, one byte lane per row byte.
// Depends on tcgr_pkg (t_font_wr).
module tcgr_font_store #(
    parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF,
    parameter int ROW_BYTES    = tcgr_pkg::ROW_BYTES_DEF
) (
    input  logic                                      i_clk,
    input  tcgr_pkg::t_font_wr                        i_wr,
    input  logic                                      i_rd_en,
    input  logic [$clog2(256*GLYPH_HEIGHT)-1:0]       i_rd_idx,
    output logic [8*ROW_BYTES-1:0]                    o_rd_word
);
    import tcgr_pkg::*;

    localparam int DEPTH      = 256 * GLYPH_HEIGHT;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int WORD_W     = 8 * ROW_BYTES;
    localparam int FONT_DEPTH = DEPTH * ROW_BYTES;
    localparam int LANE_SH    = $clog2(ROW_BYTES);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rd_word;
    logic              wr_ok;
    logic [IDX_W-1:0]  wr_idx;

    // Drop writes beyond the store.
    assign wr_ok  = i_wr.en && ({1'b0, i_wr.addr} < (ADDR_W+1)'(FONT_DEPTH));
    assign wr_idx = IDX_W'(i_wr.addr >> LANE_SH);

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < ROW_BYTES; b++) begin
            if (wr_ok && (ROW_BYTES == 1 || int'(i_wr.addr[0]) == b)) begin
                mem[wr_idx][b*8 +: 8] <= i_wr.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word <= mem[i_rd_idx];
        end
    end

    assign o_rd_word = r_rd_word;

endmodule

@@ hw/rtl/text_console_glyph_renderer.sv @@
// A glyph row passes the row sequencer, the RAM read register, then the output register.
// A drawn glyph reads one font-store row per cycle, held off while the output stalls;
// set cursor, font load, newline and unused commands read no rows.
// A glyph follows the previous one with no gap; output stalls backpressure the row reads.
// Reset (synchronous, active low): cursor to 0,0, console mode 1, margin 0, pipeline empty.
// The font store is not cleared and holds garbage until loaded.
module text_console_glyph_renderer #(
    parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF,
    parameter int GLYPH_WIDTH  = tcgr_pkg::GLYPH_WIDTH_DEF,
    parameter int ROW_BYTES    = tcgr_pkg::ROW_BYTES_DEF,
    parameter int SCREEN_WIDTH = tcgr_pkg::SCREEN_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tcgr_in_if.sink                           i_in,
    tcgr_out_if.source                        o_out
);
    import tcgr_pkg::*;

    localparam int DEPTH  = 256 * GLYPH_HEIGHT;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int WORD_W = 8 * ROW_BYTES;
    localparam int ROW_W  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
    localparam logic [ROW_W-1:0]   LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);
    localparam logic [COORD_W:0]   SW_EXT   = (COORD_W+1)'(SCREEN_WIDTH);
    localparam logic [COORD_W:0]   GW_EXT   = (COORD_W+1)'(GLYPH_WIDTH);
    localparam logic [5:0]         GH_STEP  = 6'(GLYPH_HEIGHT);

    // Add a small step to a coordinate and clamp at the top of the range.
    function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                   input logic [5:0] b);
        logic [COORD_W:0] s;
        s = {1'b0, a} + (COORD_W+1)'(b);
        return s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic               r_console_mode;
    logic [COORD_W-1:0] r_margin_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_console_mode <= 1'b1;
            r_margin_x     <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_CONSOLE_MODE) begin
                r_console_mode <= i_cfg_data[0];
            end else if (i_cfg_idx == REG_WINDOW_MARGIN) begin
                r_margin_x <= i_cfg_data;
            end
        end
    end

    // ---------------------------------------------------------------
    // Command decode and cursor update (all at the accept edge)
    // ---------------------------------------------------------------
    logic               acc;
    logic               is_put, is_lf, is_bs, is_ff, start_glyph;
    logic [CODE_W-1:0]  g_code;
    logic [COLOR_W-1:0] g_color;
    logic [COORD_W-1:0] g_x;
    logic [COORD_W-1:0] bs_x;
    logic [COORD_W:0]   adv_x;
    logic [COORD_W-1:0] r_cx, r_cy, n_cx, n_cy;

    assign acc    = i_in.valid && i_in.ready;
    assign is_put = (i_in.cmd == CMD_PUT);
    assign is_lf  = is_put && (i_in.char_code == CH_NEWLINE);
    // Backspace at column zero falls through and draws like any other code.
    assign is_bs  = is_put && (i_in.char_code == CH_BACKSPACE) && (r_cx != '0);
    assign is_ff  = is_put && (i_in.char_code == CH_FORMFEED);
    assign start_glyph = acc && is_put && !is_lf;

    assign bs_x  = ({1'b0, r_cx} > GW_EXT) ? COORD_W'({1'b0, r_cx} - GW_EXT) : '0;
    assign adv_x = {1'b0, r_cx} + GW_EXT;

    always_comb begin
        // Backspace erases the previous cell with glyph 0 and colour 0.
        g_code  = is_bs ? GLYPH_BLANK : (is_ff ? GLYPH_BLOCK : i_in.char_code);
        g_color = is_bs ? '0 : i_in.draw_color;
        g_x     = is_bs ? bs_x : r_cx;
    end

    always_comb begin
        n_cx = r_cx;
        n_cy = r_cy;
        unique case (i_in.cmd)
            CMD_CURSOR: begin
                n_cx = i_in.new_x;
                n_cy = i_in.new_y;
            end
            CMD_PUT: begin
                if (is_lf) begin
                    n_cx = r_console_mode ? '0 : r_margin_x;
                    n_cy = sat_add(r_cy, GH_STEP);
                end else if (is_bs) begin
                    n_cx = bs_x;
                end else if (adv_x >= SW_EXT) begin
                    // Wrap to the next text line.
                    n_cx = '0;
                    n_cy = sat_add(r_cy, GH_STEP);
                end else begin
                    n_cx = adv_x[COORD_W-1:0];
                end
            end
            default: begin
                // Font load and the unused code leave the cursor alone.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (acc) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end

    // ---------------------------------------------------------------
    // Row sequencer: one font-store read per glyph row
    // ---------------------------------------------------------------
    logic               r_busy;
    logic [ROW_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_base;
    logic [COORD_W-1:0] r_gx, r_gy;
    logic [COLOR_W-1:0] r_gcolor;
    logic               issue, last_issue, rd_free, o_move;

    // Read stage (RAM output register and its side data)
    logic               r_rv;
    logic [COORD_W-1:0] r_rx, r_ry;
    logic [COLOR_W-1:0] r_rcolor;
    logic               r_rlast;
    logic [WORD_W-1:0]  rd_word;

    // Output register
    logic               r_ov;
    logic [COORD_W-1:0]   r_ox, r_oy;
    logic [ROWBITS_W-1:0] r_obits;
    logic [COLOR_W-1:0]   r_ocolor;
    logic                 r_olast;

    assign o_move     = r_rv && (!r_ov || o_out.ready);
    assign rd_free    = !r_rv || o_move;
    assign issue      = r_busy && rd_free;
    assign last_issue = issue && (r_row == LAST_ROW);

    // Hold off the next command until the last row has been read: a font load
    // then lands after every read of the glyph before it.
    assign i_in.ready = !r_busy || last_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (start_glyph) begin
            r_busy <= 1'b1;
            r_row  <= '0;
        end else if (last_issue) begin
            r_busy <= 1'b0;
        end else if (issue) begin
            r_row <= r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_glyph) begin
            r_base   <= IDX_W'(g_code) * IDX_W'(GLYPH_HEIGHT);
            r_gx     <= g_x;
            r_gy     <= r_cy;
            r_gcolor <= g_color;
        end
    end

    t_font_wr font_wr;

    assign font_wr = '{en:   acc && (i_in.cmd == CMD_FONT),
                       addr: i_in.font_addr,
                       data: i_in.font_byte};

    tcgr_font_store #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .ROW_BYTES    (ROW_BYTES)
    ) u_font_store (
        .i_clk     (i_clk),
        .i_wr      (font_wr),
        .i_rd_en   (issue),
        .i_rd_idx  (r_base + IDX_W'(r_row)),
        .o_rd_word (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (issue) begin
            r_rv <= 1'b1;
        end else if (o_move) begin
            r_rv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rx     <= r_gx;
            r_ry     <= sat_add(r_gy, 6'(r_row));
            r_rcolor <= r_gcolor;
            r_rlast  <= (r_row == LAST_ROW);
        end
    end

    // Unpack the RAM word into the pixel mask, leftmost pixel in the MSB.
    logic [15:0] word_ext;
    logic [15:0] mask_ext;

    assign word_ext = 16'(rd_word);

    always_comb begin
        mask_ext = '0;
        for (int px = 0; px < 16; px++) begin
            if (px < GLYPH_WIDTH && (px / 8) < ROW_BYTES) begin
                mask_ext[GLYPH_WIDTH-1-px] = word_ext[(px/8)*8 + 7 - (px%8)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_move) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_move) begin
            r_ox     <= r_rx;
            r_oy     <= r_ry;
            r_obits  <= mask_ext[ROWBITS_W-1:0];
            r_ocolor <= r_rcolor;
            r_olast  <= r_rlast;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.pixel_x     = r_ox;
    assign o_out.pixel_y     = r_oy;
    assign o_out.row_bits    = r_obits;
    assign o_out.pixel_color = r_ocolor;
    assign o_out.last_row    = r_olast;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_row <= LAST_ROW))
        else $error("row counter ran past the last glyph row");

    a_font_after_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.cmd == CMD_FONT) |-> (!r_busy || last_issue))
        else $error("font load accepted while glyph rows remain unread");

    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && r_row != LAST_ROW) |=> (r_busy && r_row == $past(r_row) + 1'b1))
        else $error("row sequencer skipped or stalled a row");

    a_read_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_move |=> (r_ov && r_olast == $past(r_rlast)))
        else $error("read stage row lost on the way to the output register");

endmodule
